// File: hw/rtl/slc_pkg.sv
// Shared types and codes for the sound and light lamp controller.
// Used by slc_core and sound_light_lamp_controller; no dependencies.
`default_nettype none

package slc_pkg;

  localparam int DefaultTicksPerSecond = 10;
  localparam int DefaultSoundThreshold = 10;

  localparam int HitsW      = 16;
  localparam int SecondsW   = 9;
  localparam int PrescaleW  = 10;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 9;

  // Tick kinds carried on the input tuser.
  typedef enum logic [1:0] {
    TICK_SAMPLE  = 2'd0,
    TICK_WINDOW  = 2'd1,
    TICK_REFRESH = 2'd2,
    TICK_UNUSED  = 2'd3
  } tick_t;

  typedef enum logic [1:0] {
    LAMP_MANUAL    = 2'd0,
    LAMP_SOUND     = 2'd1,
    LAMP_LIGHT     = 2'd2,
    LAMP_SOUND_AND = 2'd3
  } lamp_mode_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_LAMP_MODE   = 2'd0,
    REG_ON_DURATION = 2'd1,
    REG_MANUAL_ON   = 2'd2,
    REG_NONE        = 2'd3
  } reg_index_t;

  typedef struct packed {
    lamp_mode_t          lamp_mode;
    logic [SecondsW-1:0] on_duration_s;
    logic                manual_on;
  } cfg_regs_t;

  typedef struct packed {
    tick_t mode;
    logic  sound_bit;
    logic  light_request;
  } in_item_t;

  typedef struct packed {
    logic                lamp_on;
    logic                relay_level;
    logic [SecondsW-1:0] remaining_s;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/slc_core.sv
// State update for the lamp controller: hit counter, countdown, prescaler, lamp.
// Depends on slc_pkg; one request is folded into the state per cycle.
`default_nettype none

module slc_core
  import slc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = DefaultTicksPerSecond,
  parameter int SOUND_THRESHOLD  = DefaultSoundThreshold
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire in_item_t  in_item,
  input  wire cfg_regs_t cfg,
  output out_item_t      result_next
);

  localparam logic [PrescaleW-1:0] TicksReload = PrescaleW'(TICKS_PER_SECOND);
  localparam logic [HitsW-1:0]     Threshold   = HitsW'(SOUND_THRESHOLD);

  logic [HitsW-1:0]     sound_hits, sound_hits_next;
  logic [SecondsW-1:0]  remaining, remaining_next;
  logic [PrescaleW-1:0] prescaler, prescaler_next;
  logic                 lamp_state, lamp_state_next;
  logic                 snd_active;
  logic [PrescaleW-1:0] prescaler_base;

  always_comb begin
    sound_hits_next = sound_hits;
    remaining_next  = remaining;
    prescaler_next  = prescaler;
    lamp_state_next = lamp_state;
    snd_active      = (remaining != '0);
    prescaler_base  = (prescaler == '0) ? TicksReload : prescaler;
    if (in_valid) begin
      case (in_item.mode)
        TICK_SAMPLE: begin
          if (in_item.sound_bit && (sound_hits != '1)) begin
            sound_hits_next = sound_hits + HitsW'(1);
          end
        end
        TICK_WINDOW: begin
          if (sound_hits > Threshold) begin
            remaining_next = cfg.on_duration_s;
          end
          sound_hits_next = '0;
        end
        TICK_REFRESH: begin
          case (cfg.lamp_mode)
            LAMP_MANUAL: lamp_state_next = cfg.manual_on;
            LAMP_SOUND:  lamp_state_next = snd_active;
            LAMP_LIGHT:  lamp_state_next = in_item.light_request;
            default:     lamp_state_next = snd_active & in_item.light_request;
          endcase
          // The countdown runs after the lamp decision and only while armed.
          if (snd_active) begin
            prescaler_next = prescaler_base - PrescaleW'(1);
            if (prescaler == '0) begin
              remaining_next = remaining - SecondsW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_hits <= '0;
      remaining  <= '0;
      prescaler  <= TicksReload;
      lamp_state <= 1'b0;
    end else begin
      sound_hits <= sound_hits_next;
      remaining  <= remaining_next;
      prescaler  <= prescaler_next;
      lamp_state <= lamp_state_next;
    end
  end

  assign result_next.lamp_on     = lamp_state_next;
  assign result_next.relay_level = ~lamp_state_next;
  assign result_next.remaining_s = remaining_next;

`ifndef SYNTH
  a_hits_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_item.mode == TICK_WINDOW) |=> (sound_hits == '0))
    else $error("hit counter not cleared after window end");

  a_countdown_step: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_item.mode == TICK_WINDOW) |=>
      (remaining == $past(remaining) || remaining == $past(remaining) - SecondsW'(1)))
    else $error("countdown moved by more than one second");

  a_lamp_only_refresh: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_item.mode == TICK_REFRESH) |=> $stable(lamp_state))
    else $error("lamp state changed outside a refresh tick");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/sound_light_lamp_controller.sv
// Sound and light lamp controller, top level.
// An accepted request's result is written to the output register at the edge that accepts it.
// Throughput: one request per cycle unless m_tready stalls; the output register frees when taken.
// Reset (rst, synchronous): counters cleared, prescaler at TICKS_PER_SECOND, lamp off,
// registers at mode light, 30 s duration, manual off. Depends on slc_pkg and slc_core.
`default_nettype none

module sound_light_lamp_controller
  import slc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = DefaultTicksPerSecond,
  parameter int SOUND_THRESHOLD  = DefaultSoundThreshold
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [0] sound_bit, [1] light_request
  input  wire logic [1:0]           s_tuser,   // [1:0] mode
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [15:0]               m_tdata,   // [0] lamp_on, [1] relay_level, [10:2] remaining_s
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cfg_regs_t cfg;
  in_item_t  in_item;
  out_item_t result_next, result;
  logic      in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lamp_mode     <= LAMP_LIGHT;
      cfg.on_duration_s <= SecondsW'(30);
      cfg.manual_on     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_LAMP_MODE:   cfg.lamp_mode     <= lamp_mode_t'(cfg_data[1:0]);
        REG_ON_DURATION: cfg.on_duration_s <= cfg_data[SecondsW-1:0];
        REG_MANUAL_ON:   cfg.manual_on     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The output register takes a new result whenever it is empty or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  assign in_item.mode          = tick_t'(s_tuser);
  assign in_item.sound_bit     = s_tdata[0];
  assign in_item.light_request = s_tdata[1];

  slc_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .SOUND_THRESHOLD  (SOUND_THRESHOLD)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_fire),
    .in_item     (in_item),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign m_tdata = {5'd0, result.remaining_s, result.relay_level, result.lamp_on};

`ifndef SYNTH
  a_relay_inverse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1] != m_tdata[0]))
    else $error("relay level is not the inverse of the lamp state");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output register is empty");

  a_result_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire

// File: dv/tb_sound_light_lamp_controller.sv
// Self-checking testbench for sound_light_lamp_controller: a directed table, then random
// tick traffic under several register settings, with bursty requests and receiver stalls.
// Depends on slc_pkg and the sound_light_lamp_controller RTL.
module tb_sound_light_lamp_controller;
  import slc_pkg::*;

  localparam int TicksPerSecond = DefaultTicksPerSecond;
  localparam int SoundThreshold = DefaultSoundThreshold;
  localparam int CycleLimit     = 4_000_000;
  localparam int PhaseCount     = 8;

  typedef struct packed {
    tick_t               kind;
    logic                snd;
    logic                light;
    logic                pinned;
    logic                lamp;
    logic [SecondsW-1:0] secs;
  } probe_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [15:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // Hand-typed expectation that travels with the request it belongs to.
  logic                row_pinned = 1'b0;
  logic                row_lamp = 1'b0;
  logic [SecondsW-1:0] row_secs = '0;

  // Predictor state and its copy of the registers, at their reset values.
  logic [HitsW-1:0]     hits = '0;
  logic [SecondsW-1:0]  secs_left = '0;
  logic [PrescaleW-1:0] prescale = PrescaleW'(TicksPerSecond);
  logic                 lamp = 1'b0;
  lamp_mode_t           sel_mode = LAMP_LIGHT;
  logic [SecondsW-1:0]  on_secs = 9'd30;
  logic                 manual_lamp = 1'b0;

  out_item_t lamp_due[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        cycle = 0;
  int        stall_style = 0;

  probe_row_t probe_rows [21] = '{
    '{TICK_UNUSED,  1'b1, 1'b1, 1'b1, 1'b0, 9'd0},
    '{TICK_REFRESH, 1'b0, 1'b1, 1'b1, 1'b1, 9'd0},
    '{TICK_REFRESH, 1'b1, 1'b0, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b0, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b1, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b0, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b1, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b0, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b1, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b0, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b1, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b0, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b1, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b1, 1'b0, 1'b1, 1'b0, 9'd0},
    '{TICK_SAMPLE,  1'b0, 1'b1, 1'b0, 1'b0, 9'd0},
    '{TICK_WINDOW,  1'b0, 1'b0, 1'b1, 1'b0, 9'd30},
    '{TICK_WINDOW,  1'b1, 1'b1, 1'b1, 1'b0, 9'd30},
    '{TICK_REFRESH, 1'b0, 1'b1, 1'b1, 1'b1, 9'd30},
    '{TICK_REFRESH, 1'b1, 1'b0, 1'b1, 1'b0, 9'd30},
    '{TICK_UNUSED,  1'b0, 1'b0, 1'b1, 1'b0, 9'd30},
    '{TICK_REFRESH, 1'b1, 1'b1, 1'b0, 1'b0, 9'd0}
  };

  lamp_mode_t phase_mode [PhaseCount] = '{LAMP_SOUND, LAMP_SOUND_AND, LAMP_MANUAL,
                                          LAMP_MANUAL, LAMP_LIGHT, LAMP_SOUND,
                                          LAMP_SOUND_AND, LAMP_SOUND};
  int         phase_secs [PhaseCount] = '{3, 0, 511, 1, 300, 2, 6, 4};
  logic       phase_manual [PhaseCount] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  sound_light_lamp_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver switches between stall patterns whenever the low byte of the cycle count is zero.
  always @(posedge clk) begin
    if (cycle[7:0] == 8'd0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (cycle[2:0] != 3'd5);
    endcase
  end

  function automatic out_item_t lamp_step(in_item_t req);
    out_item_t res;
    case (req.mode)
      TICK_SAMPLE: if (req.sound_bit && hits != {HitsW{1'b1}}) hits = hits + 1'b1;
      TICK_WINDOW: begin
        if (hits > SoundThreshold) secs_left = on_secs;
        hits = '0;
      end
      TICK_REFRESH: begin
        case (sel_mode)
          LAMP_MANUAL: lamp = manual_lamp;
          LAMP_SOUND:  lamp = (secs_left != 0);
          LAMP_LIGHT:  lamp = req.light_request;
          default:     lamp = (secs_left != 0) && req.light_request;
        endcase
        // The countdown only runs while seconds remain; prescaler wraps through zero.
        if (secs_left != 0) begin
          if (prescale == 0) begin
            prescale  = PrescaleW'(TicksPerSecond);
            secs_left = secs_left - 1'b1;
          end
          prescale = prescale - 1'b1;
        end
      end
      default: ;
    endcase
    res.lamp_on     = lamp;
    res.relay_level = ~lamp;
    res.remaining_s = secs_left;
    return res;
  endfunction

  task automatic flag(string what, int want, int got);
    $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    in_item_t  req;
    out_item_t want;
    out_item_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.lamp_on     = m_tdata[0];
        got.relay_level = m_tdata[1];
        got.remaining_s = m_tdata[10:2];
        if (lamp_due.size() == 0) begin
          $display("%0t: result %h with no request pending", $time, m_tdata);
          mismatches++;
        end else begin
          want = lamp_due.pop_front();
          if (got.lamp_on != want.lamp_on) flag("lamp_on", want.lamp_on, got.lamp_on);
          if (got.relay_level != want.relay_level)
            flag("relay_level", want.relay_level, got.relay_level);
          if (got.remaining_s != want.remaining_s)
            flag("remaining_s", want.remaining_s, got.remaining_s);
        end
      end
      if (s_tvalid && s_tready) begin
        req.mode          = tick_t'(s_tuser);
        req.sound_bit     = s_tdata[0];
        req.light_request = s_tdata[1];
        want = lamp_step(req);
        if (row_pinned) begin
          want.lamp_on     = row_lamp;
          want.relay_level = ~row_lamp;
          want.remaining_s = row_secs;
        end
        lamp_due.push_back(want);
      end
    end
  end

  task automatic send(tick_t kind, logic snd, logic light, logic pinned = 1'b0,
                      logic lamp_val = 1'b0, logic [SecondsW-1:0] secs = '0);
    s_tvalid   <= 1'b1;
    s_tuser    <= kind;
    s_tdata    <= {6'b0, light, snd};
    row_pinned <= pinned;
    row_lamp   <= lamp_val;
    row_secs   <= secs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 24);
    end
  endtask

  // Lowers valid, then waits for the last result to leave the queue of pending results.
  // The first edge lets a request taken at the current edge reach the queue.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (lamp_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LAMP_MODE:   sel_mode = lamp_mode_t'(value[1:0]);
      REG_ON_DURATION: on_secs = value;
      REG_MANUAL_ON:   manual_lamp = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly trigger sequences: a run of samples near the threshold, a window end, then refresh
  // ticks that drain the countdown; the rest is random ticks, sample runs, or long refresh runs.
  task automatic play_traffic(int count);
    int target;
    int kind;
    int len;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = $urandom_range(8, 14);
        repeat (len)
          send(TICK_SAMPLE, $urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)));
        send(TICK_WINDOW, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        len = $urandom_range(1, 40);
        repeat (len)
          send(($urandom_range(0, 7) == 0) ? TICK_SAMPLE : TICK_REFRESH,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (kind <= 7) begin
        len = $urandom_range(1, 10);
        repeat (len)
          send(tick_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
      end else if (kind == 8) begin
        len = $urandom_range(0, 10);
        repeat (len) send(TICK_SAMPLE, 1'b1, 1'($urandom_range(0, 1)));
        send(TICK_WINDOW, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(20, 150);
        repeat (len)
          send(TICK_REFRESH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i])
      send(probe_rows[i].kind, probe_rows[i].snd, probe_rows[i].light,
           probe_rows[i].pinned, probe_rows[i].lamp, probe_rows[i].secs);

    for (int p = 0; p < PhaseCount; p++) begin
      wait_drained();
      write_reg(REG_LAMP_MODE, CfgDataW'(phase_mode[p]));
      write_reg(REG_ON_DURATION, CfgDataW'(phase_secs[p]));
      write_reg(REG_MANUAL_ON, CfgDataW'(phase_manual[p]));
      if (p == 0) write_reg(REG_NONE, CfgDataW'($urandom_range(0, 511)));
      play_traffic(125);
    end

    wait_drained();
    if (mismatches == 0 && lamp_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/slc_pkg.sv
hw/rtl/slc_core.sv
hw/rtl/sound_light_lamp_controller.sv
dv/tb_sound_light_lamp_controller.sv
